// ===== hw/rtl/clr_pkg.sv =====
// ----------------------------------------------------------------------------
// clr_pkg
// shared types and constants for the checksummed line receiver
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChEsc     = 8'h1B;
  localparam logic [7:0] ChBracket = 8'h5B;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] SumStart  = 8'hC6;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_LF        = 4'd1,
    PH_DATA      = 4'd2,
    PH_CR        = 4'd3,
    PH_ESC       = 4'd4,
    PH_BRACKET   = 4'd5,
    PH_GT        = 4'd6,
    PH_SUM_HI_OK = 4'd7,
    PH_SUM_OK    = 4'd8
  } clr_phase_e;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2
  } clr_status_e;

  typedef enum logic [1:0] {
    SEQ_RX    = 2'd0,
    SEQ_ALIGN = 2'd1,
    SEQ_READ  = 2'd2
  } clr_seq_e;

  typedef struct packed {
    logic        wr_en;
    clr_status_e status;
    logic [5:0]  len;
  } clr_rx_res_t;

endpackage

// ===== hw/rtl/clr_cell.sv =====
// ----------------------------------------------------------------------------
// clr_cell
// one byte cell of the line store chain
// ----------------------------------------------------------------------------
module clr_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] data_i,
  output logic [7:0] data_o
);

  logic [7:0] data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== hw/rtl/clr_chain.sv =====
// ----------------------------------------------------------------------------
// clr_chain
// row of byte cells, shifting toward the tail on every enabled cycle
// ----------------------------------------------------------------------------
module clr_chain #(
  parameter int LineBytes = 32
) (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] head_i,
  output logic [7:0] tail_o
);

  logic [7:0] tap [LineBytes];

  for (genvar i = 0; i < LineBytes; i++) begin : g_cell
    logic [7:0] cell_in;
    if (i == 0) begin : g_head
      assign cell_in = head_i;
    end else begin : g_link
      assign cell_in = tap[i-1];
    end
    clr_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift_i),
      .data_i (cell_in),
      .data_o (tap[i])
    );
  end

  assign tail_o = tap[LineBytes-1];

endmodule

// ===== hw/rtl/clr_rx_fsm.sv =====
// ----------------------------------------------------------------------------
// clr_rx_fsm
// per-byte framing, running checksum and character count
// ----------------------------------------------------------------------------
module clr_rx_fsm
  import clr_pkg::*;
#(
  parameter int LineBytes = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  byte_i,
  output clr_rx_res_t res_o
);

  localparam logic [5:0] MaxCount = 6'(LineBytes - 1);

  clr_phase_e phase_q, phase_d, phase_cur;
  logic [5:0] count_q, count_d, count_cur;
  logic [7:0] sum_q, sum_d, sum_cur;
  logic       fail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      sum_q   <= SumStart;
    end else if (accept_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  always_comb begin
    phase_cur    = phase_q;
    count_cur    = count_q;
    sum_cur      = sum_q;
    phase_d      = phase_q;
    count_d      = count_q;
    sum_d        = sum_q;
    fail         = 1'b0;
    res_o.wr_en  = 1'b0;
    res_o.status = ST_BUSY;
    res_o.len    = count_q;
    if (byte_i == ChLf) begin
      res_o.status = (phase_q == PH_CR || phase_q == PH_SUM_OK) ? ST_GOOD : ST_BAD;
      phase_d      = PH_LF;
    end else begin
      // first byte after a line feed opens a new line
      if (phase_q == PH_LF) begin
        phase_cur = PH_DATA;
        count_cur = '0;
        sum_cur   = SumStart;
      end
      phase_d = phase_cur;
      count_d = count_cur;
      sum_d   = sum_cur;
      case (phase_cur)
        PH_IDLE: begin
        end
        PH_DATA: begin
          if (byte_i == ChCr) begin
            phase_d = PH_CR;
          end else if (count_cur < MaxCount) begin
            res_o.wr_en = 1'b1;
            count_d     = count_cur + 6'd1;
            sum_d       = sum_cur + byte_i;
          end else begin
            fail = 1'b1;
          end
        end
        PH_CR: begin
          if (byte_i == ChEsc) phase_d = PH_ESC; else fail = 1'b1;
        end
        PH_ESC: begin
          if (byte_i == ChBracket) phase_d = PH_BRACKET; else fail = 1'b1;
        end
        PH_BRACKET: begin
          if (byte_i == ChGt) phase_d = PH_GT; else fail = 1'b1;
        end
        PH_GT: begin
          if (byte_i == ChZero + {5'd0, sum_cur[6:4]}) phase_d = PH_SUM_HI_OK;
          else fail = 1'b1;
        end
        PH_SUM_HI_OK: begin
          if (byte_i == ChUpperA + {4'd0, sum_cur[3:0]}) phase_d = PH_SUM_OK;
          else fail = 1'b1;
        end
        default: begin
          fail = 1'b1;
        end
      endcase
      if (fail) begin
        phase_d      = PH_IDLE;
        res_o.status = ST_BAD;
      end
    end
  end

endmodule

// ===== hw/rtl/checksummed_line_receiver.sv =====
// ----------------------------------------------------------------------------
// checksummed_line_receiver
// deframes checksummed text lines from a byte stream and replays good lines
//
// channel  dir  payload
// s_axis   in   tdata[7:0] rx_byte
// m_axis   out  tdata line_status, line_char, line_length; tuser char_valid;
//               tlast last
//
// a byte is taken whenever the output register is free and no line is replayed
// a good line with at least one character is then replayed: the cell chain is
// first shifted until its first stored character reaches the tail cell, then
// each character is output from the tail; output stalls hold the chain
// reset clears framing state, checksum, count and the output valid
// ----------------------------------------------------------------------------
module checksummed_line_receiver
  import clr_pkg::*;
#(
  parameter int LINE_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // line_status[1:0], line_char[9:2], line_length[15:10]
  output logic        m_axis_tuser,   // char_valid
  output logic        m_axis_tlast
);

  localparam int CntW = (LINE_BYTES > 2) ? $clog2(LINE_BYTES) : 1;

  clr_rx_res_t rx_res;
  clr_seq_e    seq_q, seq_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic        in_acc, out_free;
  logic        shift_en;
  logic [7:0]  shift_in, tail;

  logic        out_valid_q, out_valid_d;
  clr_status_e out_status_q, out_status_d;
  logic        out_cv_q, out_cv_d;
  logic [7:0]  out_char_q, out_char_d;
  logic [5:0]  out_len_q, out_len_d;
  logic        out_last_q, out_last_d;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  clr_rx_fsm #(
    .LineBytes(LINE_BYTES)
  ) u_rx_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_acc),
    .byte_i  (s_axis_tdata),
    .res_o   (rx_res)
  );

  clr_chain #(
    .LineBytes(LINE_BYTES)
  ) u_chain (
    .clk_i  (clk_i),
    .shift_i(shift_en),
    .head_i (shift_in),
    .tail_o (tail)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_RX;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_cv_q     <= out_cv_d;
    out_char_q   <= out_char_d;
    out_len_q    <= out_len_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    seq_d         = seq_q;
    cnt_d         = cnt_q;
    s_axis_tready = 1'b0;
    shift_en      = 1'b0;
    shift_in      = 8'd0;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_status_d  = out_status_q;
    out_cv_d      = out_cv_q;
    out_char_d    = out_char_q;
    out_len_d     = out_len_q;
    out_last_d    = out_last_q;
    case (seq_q)
      SEQ_RX: begin
        s_axis_tready = out_free;
        if (in_acc) begin
          shift_en     = rx_res.wr_en;
          shift_in     = s_axis_tdata;
          out_valid_d  = 1'b1;
          out_status_d = rx_res.status;
          out_cv_d     = 1'b0;
          out_char_d   = 8'd0;
          out_len_d    = (rx_res.status == ST_GOOD) ? rx_res.len : 6'd0;
          out_last_d   = !(rx_res.status == ST_GOOD && rx_res.len != 6'd0);
          if (rx_res.status == ST_GOOD && rx_res.len != 6'd0) begin
            seq_d = SEQ_ALIGN;
            cnt_d = CntW'(LINE_BYTES - int'(rx_res.len));
          end
        end
      end
      SEQ_ALIGN: begin
        // move the first stored character to the tail cell
        shift_en = 1'b1;
        cnt_d    = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          seq_d = SEQ_READ;
          cnt_d = CntW'(out_len_q);
        end
      end
      SEQ_READ: begin
        if (out_free) begin
          shift_en     = 1'b1;
          out_valid_d  = 1'b1;
          out_status_d = ST_GOOD;
          out_cv_d     = 1'b1;
          out_char_d   = tail;
          out_last_d   = (cnt_q == CntW'(1));
          cnt_d        = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            seq_d = SEQ_RX;
          end
        end
      end
      default: begin
        seq_d = SEQ_RX;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_len_q, out_char_q, out_status_q};
  assign m_axis_tuser  = out_cv_q;
  assign m_axis_tlast  = out_last_q;

  a_nongood_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_status_q != ST_GOOD) |-> m_axis_tlast)
    else $error("busy or bad result without last");

  a_char_is_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (out_status_q == ST_GOOD && out_len_q != 6'd0))
    else $error("line character outside a good line");

  a_last_char_ends_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser && m_axis_tlast) |=> seq_q == SEQ_RX)
    else $error("replay continues after last character");

  a_bad_stays_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && rx_res.status != ST_GOOD) |=> seq_q == SEQ_RX)
    else $error("replay started on a line that is not good");

endmodule

// ===== bench/clr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clr_checker
// watches both streams of the line receiver, keeps its own copy of the line
// framing state, predicts every status and character result and compares
// each output transaction field by field against the oldest prediction
// ----------------------------------------------------------------------------
module clr_checker
  import clr_pkg::*;
#(
  parameter int LINE_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // line_status[1:0], line_char[9:2], line_length[15:10]
  input  logic        m_axis_tuser,   // char_valid
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o,
  output int          good_lines_o,
  output int          bad_lines_o,
  output int          chars_o
);

  typedef struct packed {
    clr_status_e status;
    logic        char_valid;
    logic [7:0]  line_char;
    logic [5:0]  line_length;
    logic        last;
  } line_result_t;

  clr_phase_e   frame_phase;
  logic [5:0]   char_count;
  logic [7:0]   line_sum;
  logic [7:0]   line_chars [LINE_BYTES];
  line_result_t line_results_due [$];

  task automatic deframe_byte(input logic [7:0] b);
    clr_status_e  st;
    logic         bad;
    line_result_t r;
    st  = ST_BUSY;
    bad = 1'b0;
    if (b == ChLf) begin
      st = (frame_phase == PH_CR || frame_phase == PH_SUM_OK) ? ST_GOOD : ST_BAD;
      frame_phase = PH_LF;
    end else begin
      if (frame_phase == PH_LF) begin
        frame_phase = PH_DATA;
        char_count  = '0;
        line_sum    = SumStart;
      end
      case (frame_phase)
        PH_IDLE: ;
        PH_DATA: begin
          if (b == ChCr) begin
            frame_phase = PH_CR;
          end else if (int'(char_count) < LINE_BYTES - 1) begin
            line_chars[char_count] = b;
            char_count = char_count + 6'd1;
            line_sum   = line_sum + b;
          end else begin
            bad = 1'b1;
          end
        end
        PH_CR: begin
          if (b == ChEsc) frame_phase = PH_ESC;
          else bad = 1'b1;
        end
        PH_ESC: begin
          if (b == ChBracket) frame_phase = PH_BRACKET;
          else bad = 1'b1;
        end
        PH_BRACKET: begin
          if (b == ChGt) frame_phase = PH_GT;
          else bad = 1'b1;
        end
        PH_GT: begin
          if (b == ChZero + {5'd0, line_sum[6:4]}) frame_phase = PH_SUM_HI_OK;
          else bad = 1'b1;
        end
        PH_SUM_HI_OK: begin
          if (b == ChUpperA + {4'd0, line_sum[3:0]}) frame_phase = PH_SUM_OK;
          else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        frame_phase = PH_IDLE;
        st = ST_BAD;
      end
    end

    r.status      = st;
    r.char_valid  = 1'b0;
    r.line_char   = '0;
    r.line_length = (st == ST_GOOD) ? char_count : 6'd0;
    r.last        = (st != ST_GOOD) || (char_count == 6'd0);
    line_results_due.push_back(r);
    if (st == ST_GOOD) begin
      good_lines_o++;
      for (int i = 0; i < int'(char_count); i++) begin
        r.char_valid = 1'b1;
        r.line_char  = line_chars[i];
        r.last       = (i == int'(char_count) - 1);
        line_results_due.push_back(r);
      end
    end else if (st == ST_BAD) begin
      bad_lines_o++;
    end
  endtask

  task automatic check_result(input line_result_t got);
    line_result_t want;
    if (line_results_due.size() == 0) begin
      $error("result with nothing expected: status %0d char %02h length %0d",
             got.status, got.line_char, got.line_length);
      fail_count_o++;
    end else begin
      want = line_results_due.pop_front();
      if (got.status != want.status) begin
        $error("line_status: expected %0d, got %0d", want.status, got.status);
        fail_count_o++;
      end
      if (got.char_valid != want.char_valid) begin
        $error("char_valid: expected %0d, got %0d", want.char_valid, got.char_valid);
        fail_count_o++;
      end
      if (got.line_char != want.line_char) begin
        $error("line_char: expected %02h, got %02h", want.line_char, got.line_char);
        fail_count_o++;
      end
      if (got.line_length != want.line_length) begin
        $error("line_length: expected %0d, got %0d", want.line_length, got.line_length);
        fail_count_o++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fail_count_o++;
      end
      if (got.char_valid) chars_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_phase = PH_IDLE;
      char_count  = '0;
      line_sum    = SumStart;
      line_results_due.delete();
      pending_o   = 0;
    end else begin
      // an output transaction always belongs to an earlier byte
      if (m_axis_tvalid && m_axis_tready) begin
        check_result({clr_status_e'(m_axis_tdata[1:0]), m_axis_tuser,
                      m_axis_tdata[9:2], m_axis_tdata[15:10], m_axis_tlast});
      end
      if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata);
      pending_o = line_results_due.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives byte streams into the checksummed line receiver: directed framing
// corner cases, a maximum-length and an overlong line, then random plain and
// checksummed lines with corrupted tails, trailing bytes and noise, under
// bursty input and random, patterned or no output stall; a separate checker
// predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
  import clr_pkg::*;

  localparam int LINE_BYTES = 32;
  localparam int IDLE_LIMIT = 2000;
  localparam int ITEMS      = 120;

  typedef enum int {
    FLAW_NONE,
    FLAW_TAIL,
    FLAW_TRAILING
  } line_flaw_e;

  typedef enum int {
    PACE_FULL,
    PACE_RANDOM,
    PACE_SPARSE
  } rx_pace_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int fail_count;
  int pending;
  int good_lines;
  int bad_lines;
  int chars_seen;

  int         burst_left;
  int         bytes_sent;
  int         idle_cycles;
  int         pace_count;
  rx_pace_e   rx_pace;
  logic [7:0] tx_bytes [$];

  checksummed_line_receiver #(
    .LINE_BYTES(LINE_BYTES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  clr_checker #(
    .LINE_BYTES(LINE_BYTES)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .good_lines_o  (good_lines),
    .bad_lines_o   (bad_lines),
    .chars_o       (chars_seen)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    pace_count++;
    if (pace_count % 64 == 0) rx_pace = rx_pace_e'($urandom_range(0, 2));
    case (rx_pace)
      PACE_FULL:   m_axis_tready <= 1'b1;
      PACE_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
      default:     m_axis_tready <= (pace_count % 4 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ChLf || b == ChCr);
    return b;
  endfunction

  function automatic int pick_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(7, LINE_BYTES - 1);
    return $urandom_range(0, 6);
  endfunction

  task automatic send_line(input int n, input bit with_sum, input line_flaw_e flaw);
    logic [7:0] sum;
    int         pos;
    sum = SumStart;
    tx_bytes.delete();
    for (int i = 0; i < n; i++) begin
      tx_bytes.push_back(data_byte());
      sum = sum + tx_bytes[i];
    end
    tx_bytes.push_back(ChCr);
    if (with_sum) begin
      tx_bytes.push_back(ChEsc);
      tx_bytes.push_back(ChBracket);
      tx_bytes.push_back(ChGt);
      tx_bytes.push_back(ChZero + {5'd0, sum[6:4]});
      tx_bytes.push_back(ChUpperA + {4'd0, sum[3:0]});
    end
    if (flaw == FLAW_TAIL) begin
      pos = $urandom_range(n, tx_bytes.size() - 1);
      tx_bytes[pos] = tx_bytes[pos] ^ 8'($urandom_range(1, 255));
    end else if (flaw == FLAW_TRAILING) begin
      tx_bytes.push_back(data_byte());
    end
    tx_bytes.push_back(ChLf);
    foreach (tx_bytes[i]) send_byte(tx_bytes[i]);
  endtask

  initial begin
    int pick;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    burst_left    = 0;
    bytes_sent    = 0;
    idle_cycles   = 0;
    pace_count    = 0;
    rx_pace       = PACE_FULL;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // idle byte, then the first line feed after reset
    send_byte(8'hFF);
    send_byte(ChLf);
    send_line(0, 1'b0, FLAW_NONE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChCr);
    send_byte(ChLf);
    send_line(2, 1'b1, FLAW_NONE);
    send_line(0, 1'b1, FLAW_TRAILING);

    // longest good line, then one data byte too many
    send_line(LINE_BYTES - 1, 1'b1, FLAW_NONE);
    send_line(LINE_BYTES, 1'b0, FLAW_NONE);

    while (bytes_sent < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_line(pick_length(), 1'b1, FLAW_NONE);
      else if (pick < 65)
        send_line(pick_length(), 1'b0, FLAW_NONE);
      else if (pick < 85)
        send_line(pick_length(), 1'b1, ($urandom_range(0, 1) == 0) ? FLAW_TAIL : FLAW_TRAILING);
      else
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (LINE_BYTES + 8) @(posedge clk_i);
    $display("covered %0d input bytes: %0d good lines with %0d characters replayed, %0d bad lines",
             bytes_sent, good_lines, chars_seen, bad_lines);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== checksummed_line_receiver.f =====
hw/rtl/clr_pkg.sv
hw/rtl/clr_cell.sv
hw/rtl/clr_chain.sv
hw/rtl/clr_rx_fsm.sv
hw/rtl/checksummed_line_receiver.sv
bench/clr_checker.sv
bench/testbench.sv
